/* hw/rtl/crc32_packet_deframer_assert.svh */
// Assertion macros shared by the deframer RTL.
`ifndef CRC32_PACKET_DEFRAMER_ASSERT_SVH
`define CRC32_PACKET_DEFRAMER_ASSERT_SVH

`ifndef SYNTH
`define CRCDF_ASSERT(label, clock, reset_n, prop, msg) \
    label: assert property (@(posedge clock) disable iff (!reset_n) prop) else $error(msg);
`define CRCDF_ASSERT_ALWAYS(label, clock, prop, msg) \
    label: assert property (@(posedge clock) prop) else $error(msg);
`else
`define CRCDF_ASSERT(label, clock, reset_n, prop, msg)
`define CRCDF_ASSERT_ALWAYS(label, clock, prop, msg)
`endif

`endif

/* hw/rtl/crcdf_pkg.sv */
package crcdf_pkg;

    localparam int HEADER_BYTES = 16;
    localparam int HDR_IDX_W = $clog2(HEADER_BYTES + 1);
    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;

    typedef enum logic [2:0] {
        ST_OK           = 3'd0,
        ST_TOO_SHORT    = 3'd1,
        ST_BAD_MAGIC    = 3'd2,
        ST_LEN_MISMATCH = 3'd3,
        ST_CRC_MISMATCH = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        HW_MAGIC    = 2'd0,
        HW_LENGTH   = 2'd1,
        HW_SEQUENCE = 2'd2,
        HW_CRC      = 2'd3
    } hdr_word_t;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       end_of_frame;
    } frame_req_t;

    typedef struct packed {
        logic        payload_valid;
        logic [7:0]  payload_byte;
        logic        frame_done;
        status_t     status;
        logic [31:0] sequence_number;
        logic [31:0] payload_length;
    } report_req_t;

    // Reflected CRC-32 update over one byte, least significant bit first.
    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

/* hw/rtl/crc32_packet_deframer.sv */
// Length-prefixed frame deframer with CRC-32 check. One frame byte is taken per request on the
// frame channel, and a new request can be accepted in every clock cycle while frame_stall is low.
// The first sixteen bytes are a big-endian header of magic, payload length, sequence and CRC
// words; header bytes give no report unless they end the frame. Every later byte is passed out
// on the report channel and folded into a reflected CRC-32, and the report for the byte marked
// end_of_frame also carries the frame status and, unless the frame is too short, its sequence
// and length. A byte is held in an input register, processed in a single pass of CRC and compare
// logic, and its report sits in an output register; a stall keeps a byte in the input register.
// Stall on the report channel reaches frame_stall in the same cycle only while the held byte would
// produce a report. The magic register must be written only while no frame byte is in flight.
module crc32_packet_deframer
    import crcdf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        magic_we,
    input  logic [31:0] magic_wdata,
    input  logic        frame_valid,
    output logic        frame_stall,
    input  frame_req_t  frame_req,
    output logic        report_valid,
    input  logic        report_stall,
    output report_req_t report_req
);

`include "crc32_packet_deframer_assert.svh"

    localparam logic [HDR_IDX_W-1:0] HDR_FULL = HDR_IDX_W'(HEADER_BYTES);

    logic [31:0]          magic_word_reg;
    logic                 in_valid_reg;
    frame_req_t           in_req_reg;
    logic                 res_valid_reg;
    report_req_t          res_req_reg;

    logic [HDR_IDX_W-1:0] header_index_reg, header_index_next;
    logic [31:0]          header_shift_reg, header_shift_next;
    logic                 magic_ok_reg, magic_ok_next;
    logic [31:0]          declared_length_reg, declared_length_next;
    logic [31:0]          sequence_reg, sequence_next;
    logic [31:0]          expected_crc_reg, expected_crc_next;
    logic [31:0]          running_crc_reg, running_crc_next;
    logic [31:0]          payload_count_reg, payload_count_next;

    logic                 is_payload;
    logic                 emits;
    logic                 process;
    status_t              status_next;
    report_req_t          res_req_next;

    assign is_payload = (header_index_reg == HDR_FULL);
    assign emits = is_payload || in_req_reg.end_of_frame;
    assign process = in_valid_reg && (!emits || !res_valid_reg || !report_stall);
    assign frame_stall = in_valid_reg && !process;

    assign report_valid = res_valid_reg;
    assign report_req = res_req_reg;

    always_comb
    begin
        header_index_next    = header_index_reg;
        header_shift_next    = header_shift_reg;
        magic_ok_next        = magic_ok_reg;
        declared_length_next = declared_length_reg;
        sequence_next        = sequence_reg;
        expected_crc_next    = expected_crc_reg;
        running_crc_next     = running_crc_reg;
        payload_count_next   = payload_count_reg;

        if (!is_payload)
        begin
            header_shift_next = {header_shift_reg[23:0], in_req_reg.rx_byte};
            if (header_index_reg[1:0] == 2'b11)
            begin
                unique case (hdr_word_t'(header_index_reg[3:2]))
                    HW_MAGIC:    magic_ok_next = (header_shift_next == magic_word_reg);
                    HW_LENGTH:   declared_length_next = header_shift_next;
                    HW_SEQUENCE: sequence_next = header_shift_next;
                    HW_CRC:      expected_crc_next = header_shift_next;
                    default:     expected_crc_next = header_shift_next;
                endcase
            end
            header_index_next = header_index_reg + HDR_IDX_W'(1);
        end
        else
        begin
            running_crc_next = crc_byte(running_crc_reg, in_req_reg.rx_byte);
            if (payload_count_reg != '1)
            begin
                payload_count_next = payload_count_reg + 32'd1;
            end
        end

        if (header_index_next != HDR_FULL)
        begin
            status_next = ST_TOO_SHORT;
        end
        else if (!magic_ok_next)
        begin
            status_next = ST_BAD_MAGIC;
        end
        else if (payload_count_next != declared_length_next)
        begin
            status_next = ST_LEN_MISMATCH;
        end
        else if (~running_crc_next != expected_crc_next)
        begin
            status_next = ST_CRC_MISMATCH;
        end
        else
        begin
            status_next = ST_OK;
        end

        res_req_next.payload_valid   = is_payload;
        res_req_next.payload_byte    = is_payload ? in_req_reg.rx_byte : 8'd0;
        res_req_next.frame_done      = in_req_reg.end_of_frame;
        res_req_next.status          = ST_OK;
        res_req_next.sequence_number = 32'd0;
        res_req_next.payload_length  = 32'd0;
        if (in_req_reg.end_of_frame)
        begin
            res_req_next.status = status_next;
            if (status_next != ST_TOO_SHORT)
            begin
                res_req_next.sequence_number = sequence_next;
                res_req_next.payload_length  = declared_length_next;
            end
        end

        // The frame's last byte returns all frame state to its start value.
        if (in_req_reg.end_of_frame)
        begin
            header_index_next    = '0;
            header_shift_next    = '0;
            magic_ok_next        = 1'b0;
            declared_length_next = '0;
            sequence_next        = '0;
            expected_crc_next    = '0;
            running_crc_next     = '1;
            payload_count_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            magic_word_reg <= '0;
        end
        else if (magic_we)
        begin
            magic_word_reg <= magic_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!frame_stall)
        begin
            in_valid_reg <= frame_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (frame_valid && !frame_stall)
        begin
            in_req_reg <= frame_req;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (process && emits)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (!report_stall)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (process && emits)
        begin
            res_req_reg <= res_req_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_index_reg    <= '0;
            header_shift_reg    <= '0;
            magic_ok_reg        <= 1'b0;
            declared_length_reg <= '0;
            sequence_reg        <= '0;
            expected_crc_reg    <= '0;
            running_crc_reg     <= '1;
            payload_count_reg   <= '0;
        end
        else if (process)
        begin
            header_index_reg    <= header_index_next;
            header_shift_reg    <= header_shift_next;
            magic_ok_reg        <= magic_ok_next;
            declared_length_reg <= declared_length_next;
            sequence_reg        <= sequence_next;
            expected_crc_reg    <= expected_crc_next;
            running_crc_reg     <= running_crc_next;
            payload_count_reg   <= payload_count_next;
        end
    end

    `CRCDF_ASSERT(a_index_bounded, clk, rst_n,
        header_index_reg <= HDR_FULL,
        "header index overran")
    `CRCDF_ASSERT(a_no_empty_report, clk, rst_n,
        res_valid_reg |-> (res_req_reg.payload_valid || res_req_reg.frame_done),
        "report with neither payload nor frame end")
    `CRCDF_ASSERT(a_status_only_at_end, clk, rst_n,
        (res_valid_reg && !res_req_reg.frame_done) |-> (res_req_reg.status == ST_OK),
        "status set on a report that does not end a frame")
    `CRCDF_ASSERT(a_short_has_no_payload, clk, rst_n,
        (res_valid_reg && res_req_reg.status == ST_TOO_SHORT) |-> !res_req_reg.payload_valid,
        "short frame report carries payload")
    `CRCDF_ASSERT(a_clear_after_end, clk, rst_n,
        (process && in_req_reg.end_of_frame) |=>
            (header_index_reg == '0 && running_crc_reg == '1 && payload_count_reg == '0),
        "frame state not cleared after frame end")

endmodule
